// ===== src/variable_ratio_polyphase_resampler_core_assert.svh =====
// Assertion macros shared by the resampler RTL.
`ifndef VARIABLE_RATIO_POLYPHASE_RESAMPLER_CORE_ASSERT_SVH
`define VARIABLE_RATIO_POLYPHASE_RESAMPLER_CORE_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define VRPR_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define VRPR_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define VRPR_ASSERT_SAME(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

`endif

// ===== src/vrpr_pkg.sv =====
// Shared constants, codes and types of the variable-ratio resampler.
`timescale 1ns / 1ps
package vrpr_pkg;

   localparam int MAX_HALF_LENGTH = 64;
   localparam int MAX_PHASES      = 64;
   localparam int SAMPLE_BITS     = 24;
   localparam int COEF_BITS       = 24;
   localparam int PHASE_FRAC_BITS = 32;
   localparam int RESULT_CAP      = 64;

   localparam int HL_W        = 7;
   localparam int NP_W        = 7;
   localparam int STEP_W      = 42;
   localparam int WEIGHT_W    = 16;
   localparam int ADDR_W      = 13;
   localparam int HL_MIN      = 16;
   localparam int NP_MIN      = 2;

   localparam int RING_LEN    = 2 * MAX_HALF_LENGTH;
   localparam int RING_AW     = $clog2(RING_LEN);
   localparam int COEF_DEPTH  = (MAX_PHASES + 1) * MAX_HALF_LENGTH;
   localparam int COEF_AW     = $clog2(COEF_DEPTH);
   localparam int TAP_W       = RING_AW;
   localparam int SN_W        = RING_AW + 1;
   localparam int CNT_W       = $clog2(RESULT_CAP) + 1;
   localparam int PH_INT_W    = $clog2(MAX_PHASES);
   localparam int PHASE_W     = PH_INT_W + PHASE_FRAC_BITS;
   localparam int SUM_W       = STEP_W + 1;
   localparam int SUM_INT_W   = SUM_W - PHASE_FRAC_BITS;
   localparam int DIV_CNT_W   = $clog2(SUM_INT_W);
   localparam int WB_W        = 16;
   localparam int BLEND_P_W   = WB_W + 2 + COEF_BITS;
   localparam int MUL_W       = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W       = MUL_W + RING_AW + 1;
   localparam int PROD_W      = WEIGHT_W + 1 + SUM_W;
   localparam int OUT_SHIFT   = COEF_BITS - 1;

   // Reset values of the registers and of the sample demand
   localparam logic [HL_W-1:0]   HL_RESET     = HL_W'(32);
   localparam logic [NP_W-1:0]   NP_RESET     = NP_W'(32);
   localparam logic [STEP_W-1:0] STEP_RESET   = STEP_W'(64'd32 << PHASE_FRAC_BITS);
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(655);
   localparam logic [SN_W-1:0]   SN_RESET     = SN_W'(64);

   // Input item kinds on req_tuser
   localparam logic [1:0] OP_REAL = 2'd0;
   localparam logic [1:0] OP_ZERO = 2'd1;
   localparam logic [1:0] OP_COEF = 2'd2;
   localparam logic [1:0] OP_NONE = 2'd3;

   // Register indexes on the csr channel
   localparam logic [1:0] REG_HALF_LENGTH = 2'd0;
   localparam logic [1:0] REG_NUM_PHASES  = 2'd1;
   localparam logic [1:0] REG_TARGET_STEP = 2'd2;
   localparam logic [1:0] REG_STEP_WEIGHT = 2'd3;

   // Placement of fields in req_tdata
   localparam int REQ_DATA_W   = 64;
   localparam int SAMPLE_LSB   = 0;
   localparam int CADDR_LSB    = SAMPLE_LSB + SAMPLE_BITS;
   localparam int CVALUE_LSB   = CADDR_LSB + ADDR_W;

   typedef struct packed {
      logic             coef_wr;
      logic             item_load;
      logic             step_load;
      logic             sample_wr;
      logic             div_k_start;
      logic             k_load;
      logic             base_load;
      logic             mac_clear;
      logic             mac_issue;
      logic [TAP_W-1:0] tap;
      logic             step_mul;
      logic             step_upd;
      logic             adv_start;
      logic             adv_apply;
      logic             out_load;
      logic             out_last;
   } ctl_cmd_type;

   typedef struct packed {
      logic            sn_zero;
      logic            sn_one;
      logic            div_busy;
      logic            mac_busy;
      logic [SN_W-1:0] two_hl;
   } dp_status_type;

endpackage

// ===== src/vrpr_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
module vrpr_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write, and register both reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
   end

endmodule

// ===== src/vrpr_ctrl.sv =====
// Controller state machine: item sequencing, output loop, tap walk and result handshake.
`timescale 1ns / 1ps
`include "variable_ratio_polyphase_resampler_core_assert.svh"
module vrpr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [1:0]             req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  vrpr_pkg::dp_status_type status,
   output vrpr_pkg::ctl_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_CHECK   = 4'd1;
   localparam logic [3:0] S_KDIV    = 4'd2;
   localparam logic [3:0] S_BASE    = 4'd3;
   localparam logic [3:0] S_MAC     = 4'd4;
   localparam logic [3:0] S_DRAIN   = 4'd5;
   localparam logic [3:0] S_STEPMUL = 4'd6;
   localparam logic [3:0] S_STEPUPD = 4'd7;
   localparam logic [3:0] S_ADVST   = 4'd8;
   localparam logic [3:0] S_ADIV    = 4'd9;
   localparam logic [3:0] S_ADVAPP  = 4'd10;
   localparam logic [3:0] S_EMIT    = 4'd11;

   localparam logic [vrpr_pkg::CNT_W-1:0] CAP = vrpr_pkg::CNT_W'(vrpr_pkg::RESULT_CAP);

   logic [3:0]                    state_ff, state_in;
   logic [vrpr_pkg::TAP_W-1:0]    tap_ff, tap_in;
   logic [vrpr_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic                          loop1_ff, loop1_in;
   logic                          running_ff, running_in;
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [vrpr_pkg::TAP_W-1:0]    tap_last;

   assign rsp_tvalid = rsp_tvalid_ff;
   assign tap_last   = vrpr_pkg::TAP_W'(status.two_hl - vrpr_pkg::SN_W'(1));

   // Next state and commands
   always_comb begin
      state_in      = state_ff;
      tap_in        = tap_ff;
      cnt_in        = cnt_ff;
      loop1_in      = loop1_ff;
      running_in    = running_ff;
      rsp_tvalid_in = rsp_tvalid_ff & ~rsp_tready;
      cmd           = '0;
      cmd.tap       = tap_ff;
      req_tready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_tuser == vrpr_pkg::OP_COEF) begin
                  cmd.coef_wr = 1'b1;
               end else if (req_tuser == vrpr_pkg::OP_REAL ||
                            req_tuser == vrpr_pkg::OP_ZERO) begin
                  cmd.item_load = 1'b1;
                  cmd.step_load = ~running_ff;
                  running_in    = 1'b1;
                  cnt_in        = '0;
                  loop1_in      = 1'b1;
                  state_in      = S_CHECK;
               end
            end
         end
         S_CHECK: begin
            if (status.sn_zero && cnt_ff < CAP) begin
               cmd.div_k_start = 1'b1;
               state_in        = S_KDIV;
            end else if (loop1_ff && !status.sn_zero) begin
               cmd.sample_wr = 1'b1;
               loop1_in      = 1'b0;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_KDIV: begin
            if (!status.div_busy) begin
               cmd.k_load = 1'b1;
               state_in   = S_BASE;
            end
         end
         S_BASE: begin
            cmd.base_load = 1'b1;
            cmd.mac_clear = 1'b1;
            tap_in        = '0;
            state_in      = S_MAC;
         end
         S_MAC: begin
            cmd.mac_issue = 1'b1;
            tap_in        = tap_ff + vrpr_pkg::TAP_W'(1);
            if (tap_ff == tap_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!status.mac_busy) begin
               state_in = S_STEPMUL;
            end
         end
         S_STEPMUL: begin
            cmd.step_mul = 1'b1;
            state_in     = S_STEPUPD;
         end
         S_STEPUPD: begin
            cmd.step_upd = 1'b1;
            state_in     = S_ADVST;
         end
         S_ADVST: begin
            cmd.adv_start = 1'b1;
            state_in      = S_ADIV;
         end
         S_ADIV: begin
            if (!status.div_busy) begin
               state_in = S_ADVAPP;
            end
         end
         S_ADVAPP: begin
            cmd.adv_apply = 1'b1;
            state_in      = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.out_load  = 1'b1;
               cmd.out_last  = (cnt_ff + vrpr_pkg::CNT_W'(1) == CAP) ||
                               (!status.sn_zero && !(loop1_ff && status.sn_one));
               rsp_tvalid_in = 1'b1;
               cnt_in        = cnt_ff + vrpr_pkg::CNT_W'(1);
               state_in      = S_CHECK;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         tap_ff        <= '0;
         cnt_ff        <= '0;
         loop1_ff      <= 1'b0;
         running_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tap_ff        <= tap_in;
         cnt_ff        <= cnt_in;
         loop1_ff      <= loop1_in;
         running_ff    <= running_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   `VRPR_ASSERT_ALWAYS(a_cap_bound, cnt_ff <= CAP, "result count above cap")
   `VRPR_ASSERT_SAME(a_out_slot_free, cmd.out_load, !rsp_tvalid_ff || rsp_tready,
      "result overwritten while waiting")
   `VRPR_ASSERT_NEXT(a_mac_to_drain, state_ff == S_MAC && tap_ff == tap_last,
      state_ff == S_DRAIN, "tap walk did not end at window end")
   `VRPR_ASSERT_SAME(a_mac_div_idle, state_ff == S_MAC, !status.div_busy,
      "divider busy during tap walk")

endmodule

// ===== src/vrpr_datapath.sv =====
// Datapath: registers, phase arithmetic, divider, history and coefficient memories, MAC pipe.
`timescale 1ns / 1ps
`include "variable_ratio_polyphase_resampler_core_assert.svh"
module vrpr_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [1:0]                          csr_index,
   input  logic [vrpr_pkg::STEP_W-1:0]         csr_data,
   input  logic [vrpr_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [1:0]                          req_tuser,
   input  vrpr_pkg::ctl_cmd_type               cmd,
   output vrpr_pkg::dp_status_type             status,
   output logic [vrpr_pkg::SAMPLE_BITS-1:0]    rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int SB  = vrpr_pkg::SAMPLE_BITS;
   localparam int CB  = vrpr_pkg::COEF_BITS;
   localparam int SNW = vrpr_pkg::SN_W;
   localparam int RAW = vrpr_pkg::RING_AW;
   localparam int CAW = vrpr_pkg::COEF_AW;
   localparam int YW  = vrpr_pkg::ACC_W - vrpr_pkg::OUT_SHIFT;

   // Configuration registers
   logic [vrpr_pkg::HL_W-1:0]     hl_ff;
   logic [vrpr_pkg::NP_W-1:0]     np_ff;
   logic [vrpr_pkg::STEP_W-1:0]   target_ff;
   logic [vrpr_pkg::WEIGHT_W-1:0] weight_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hl_ff     <= vrpr_pkg::HL_RESET;
         np_ff     <= vrpr_pkg::NP_RESET;
         target_ff <= vrpr_pkg::STEP_RESET;
         weight_ff <= vrpr_pkg::WEIGHT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            vrpr_pkg::REG_HALF_LENGTH: hl_ff     <= csr_data[vrpr_pkg::HL_W-1:0];
            vrpr_pkg::REG_NUM_PHASES:  np_ff     <= csr_data[vrpr_pkg::NP_W-1:0];
            vrpr_pkg::REG_TARGET_STEP: target_ff <= csr_data;
            vrpr_pkg::REG_STEP_WEIGHT: weight_ff <= csr_data[vrpr_pkg::WEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp half length and phase count into their working ranges
   logic [vrpr_pkg::HL_W-1:0] hl_eff;
   logic [vrpr_pkg::NP_W-1:0] np_eff;
   logic [SNW-1:0]            two_hl;

   always_comb begin
      if (hl_ff < vrpr_pkg::HL_W'(vrpr_pkg::HL_MIN)) begin
         hl_eff = vrpr_pkg::HL_W'(vrpr_pkg::HL_MIN);
      end else if (hl_ff > vrpr_pkg::HL_W'(vrpr_pkg::MAX_HALF_LENGTH)) begin
         hl_eff = vrpr_pkg::HL_W'(vrpr_pkg::MAX_HALF_LENGTH);
      end else begin
         hl_eff = hl_ff;
      end
      if (np_ff < vrpr_pkg::NP_W'(vrpr_pkg::NP_MIN)) begin
         np_eff = vrpr_pkg::NP_W'(vrpr_pkg::NP_MIN);
      end else if (np_ff > vrpr_pkg::NP_W'(vrpr_pkg::MAX_PHASES)) begin
         np_eff = vrpr_pkg::NP_W'(vrpr_pkg::MAX_PHASES);
      end else begin
         np_eff = np_ff;
      end
   end

   assign two_hl = {hl_eff, 1'b0};

   // Filter state
   logic [RAW-1:0]                  ws_ff;
   logic [SNW-1:0]                  sn_ff;
   logic [SNW-1:0]                  zr_ff;
   logic [vrpr_pkg::PHASE_W-1:0]    phase_ff;
   logic [vrpr_pkg::STEP_W-1:0]     ps_ff;
   logic                            item_zero_ff;
   logic [SB-1:0]                   item_sample_ff;
   logic [vrpr_pkg::PH_INT_W-1:0]   k_ff;
   logic [CAW-1:0]                  r1_ff, r2_ff;
   logic [vrpr_pkg::PROD_W-1:0]     prod_ff;
   logic                            dnz_ff;
   logic [vrpr_pkg::PHASE_FRAC_BITS-1:0] frac_ff;

   // Shared divider: integer part of the phase, or of phase plus step, by phase count, one quotient bit a cycle
   logic                              div_busy_ff;
   logic [vrpr_pkg::DIV_CNT_W-1:0]    div_cnt_ff;
   logic [vrpr_pkg::SUM_INT_W-1:0]    div_num_ff;
   logic [vrpr_pkg::NP_W-1:0]         div_rem_ff;
   logic [vrpr_pkg::NP_W:0]           div_trial;
   logic                              div_ge;
   logic [vrpr_pkg::SUM_INT_W-1:0]    div_dividend;
   logic [vrpr_pkg::SUM_W-1:0]        phase_sum;

   assign phase_sum = vrpr_pkg::SUM_W'(phase_ff) + vrpr_pkg::SUM_W'(ps_ff);
   assign div_dividend = cmd.adv_start ?
                         phase_sum[vrpr_pkg::SUM_W-1:vrpr_pkg::PHASE_FRAC_BITS] :
                         vrpr_pkg::SUM_INT_W'(phase_ff[vrpr_pkg::PHASE_W-1:
                                                       vrpr_pkg::PHASE_FRAC_BITS]);
   assign div_trial = {div_rem_ff, div_num_ff[vrpr_pkg::SUM_INT_W-1]};
   assign div_ge    = div_trial >= {1'b0, np_eff};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         div_cnt_ff  <= '0;
      end else if (cmd.div_k_start || cmd.adv_start) begin
         div_busy_ff <= 1'b1;
         div_cnt_ff  <= '0;
      end else if (div_busy_ff) begin
         div_cnt_ff <= div_cnt_ff + vrpr_pkg::DIV_CNT_W'(1);
         if (div_cnt_ff == vrpr_pkg::DIV_CNT_W'(vrpr_pkg::SUM_INT_W - 1)) begin
            div_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_k_start || cmd.adv_start) begin
         div_num_ff <= div_dividend;
         div_rem_ff <= '0;
      end else if (div_busy_ff) begin
         div_num_ff <= {div_num_ff[vrpr_pkg::SUM_INT_W-2:0], div_ge};
         div_rem_ff <= div_ge ? vrpr_pkg::NP_W'(div_trial - {1'b0, np_eff}) :
                                vrpr_pkg::NP_W'(div_trial);
      end
   end

   // Phase step smoothing toward the target
   logic signed [vrpr_pkg::SUM_W-1:0]  step_diff;
   logic signed [vrpr_pkg::PROD_W-1:0] prod_rnd;
   logic signed [vrpr_pkg::PROD_W-1:0] prod_shr;
   logic [vrpr_pkg::STEP_W-1:0]        inc_lo;
   logic                               inc_zero;

   assign step_diff = $signed({1'b0, target_ff}) - $signed({1'b0, ps_ff});
   assign prod_rnd  = prod_ff[vrpr_pkg::PROD_W-1] ?
                      $signed(prod_ff) + vrpr_pkg::PROD_W'((1 << vrpr_pkg::WB_W) - 1) :
                      $signed(prod_ff);
   assign prod_shr  = prod_rnd >>> vrpr_pkg::WB_W;
   assign inc_lo    = prod_shr[vrpr_pkg::STEP_W-1:0];
   assign inc_zero  = (prod_shr == '0);

   // Write position of the next sample in the ring
   logic [SNW-1:0] wr_pos_full;
   assign wr_pos_full = SNW'(ws_ff) + two_hl - sn_ff;

   // Item, step, phase and window bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff    <= '0;
         sn_ff    <= vrpr_pkg::SN_RESET;
         zr_ff    <= '0;
         phase_ff <= '0;
         ps_ff    <= vrpr_pkg::STEP_RESET;
      end else begin
         if (cmd.step_load) begin
            ps_ff <= target_ff;
         end else if (cmd.step_upd) begin
            if (inc_zero && dnz_ff && weight_ff != '0) begin
               ps_ff <= target_ff;
            end else begin
               ps_ff <= ps_ff + inc_lo;
            end
         end
         if (cmd.sample_wr) begin
            sn_ff <= sn_ff - SNW'(1);
            if (!item_zero_ff) begin
               zr_ff <= '0;
            end else if (zr_ff < two_hl) begin
               zr_ff <= zr_ff + SNW'(1);
            end
         end
         if (cmd.adv_apply) begin
            phase_ff <= {div_rem_ff[vrpr_pkg::PH_INT_W-1:0], frac_ff};
            ws_ff    <= ws_ff + div_num_ff[RAW-1:0];
            sn_ff    <= (div_num_ff > vrpr_pkg::SUM_INT_W'(two_hl)) ? two_hl :
                        div_num_ff[SNW-1:0];
         end
      end
   end

   // Payload registers of the item and per-output working values
   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         item_zero_ff   <= (req_tuser == vrpr_pkg::OP_ZERO);
         item_sample_ff <= req_tdata[vrpr_pkg::SAMPLE_LSB +: SB];
      end
      if (cmd.k_load) begin
         k_ff <= div_rem_ff[vrpr_pkg::PH_INT_W-1:0];
      end
      if (cmd.base_load) begin
         r1_ff <= CAW'(k_ff * hl_eff);
         r2_ff <= CAW'((np_eff - vrpr_pkg::NP_W'(k_ff)) * hl_eff);
      end
      if (cmd.step_mul) begin
         prod_ff <= vrpr_pkg::PROD_W'($signed({1'b0, weight_ff}) * step_diff);
         dnz_ff  <= (step_diff != '0);
      end
      if (cmd.adv_start) begin
         frac_ff <= phase_sum[vrpr_pkg::PHASE_FRAC_BITS-1:0];
      end
   end

   // Coefficient memory, written by coefficient items
   logic [CAW-1:0]  coef_waddr;
   logic            coef_we;
   logic [CAW-1:0]  coef_ra, coef_rb;
   logic [CB-1:0]   coef_da, coef_db;
   logic [RAW-2:0]  tap_i;
   logic            tap_h;

   assign coef_waddr = req_tdata[vrpr_pkg::CADDR_LSB +: CAW];
   assign coef_we    = cmd.coef_wr && (coef_waddr < CAW'(vrpr_pkg::COEF_DEPTH));
   assign tap_i      = cmd.tap[RAW-1:1];
   assign tap_h      = cmd.tap[0];
   assign coef_ra    = tap_h ? r2_ff + CAW'(tap_i) : r1_ff + CAW'(tap_i);
   assign coef_rb    = tap_h ? r2_ff - CAW'(hl_eff) + CAW'(tap_i) :
                               r1_ff + CAW'(hl_eff) + CAW'(tap_i);

   vrpr_ram #(
      .WIDTH (CB),
      .DEPTH (vrpr_pkg::COEF_DEPTH)
   ) u_coef_ram (
      .clock     (clock),
      .wr_en     (coef_we),
      .wr_addr   (coef_waddr),
      .wr_data   (req_tdata[vrpr_pkg::CVALUE_LSB +: CB]),
      .rd_addr_a (coef_ra),
      .rd_data_a (coef_da),
      .rd_addr_b (coef_rb),
      .rd_data_b (coef_db)
   );

   // History ring; entries never written read as zero
   localparam int RING_LEN_T = vrpr_pkg::RING_LEN;
   logic [RING_LEN_T-1:0] hist_vld_ff;
   logic [RAW-1:0]  hist_wa, hist_ra, hist_rb;
   logic [SB-1:0]   hist_wd, hist_da, hist_db;
   logic            hva_ff, hvb_ff;
   logic [SNW-1:0]  hist_rb_full;

   assign hist_wa      = wr_pos_full[RAW-1:0];
   assign hist_wd      = item_zero_ff ? '0 : item_sample_ff;
   assign hist_ra      = ws_ff + RAW'(tap_i);
   assign hist_rb_full = SNW'(ws_ff) + two_hl - SNW'(1) - SNW'(tap_i);
   assign hist_rb      = hist_rb_full[RAW-1:0];

   vrpr_ram #(
      .WIDTH (SB),
      .DEPTH (vrpr_pkg::RING_LEN)
   ) u_hist_ram (
      .clock     (clock),
      .wr_en     (cmd.sample_wr),
      .wr_addr   (hist_wa),
      .wr_data   (hist_wd),
      .rd_addr_a (hist_ra),
      .rd_data_a (hist_da),
      .rd_addr_b (hist_rb),
      .rd_data_b (hist_db)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_vld_ff <= '0;
      end else if (cmd.sample_wr) begin
         hist_vld_ff[hist_wa] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      hva_ff <= hist_vld_ff[hist_ra];
      hvb_ff <= hist_vld_ff[hist_rb];
   end

   // MAC pipe: read, blend products, blend round, tap product, accumulate
   logic                               v1_ff, v2_ff, v3_ff, v4_ff;
   logic                               h1_ff;
   logic signed [vrpr_pkg::BLEND_P_W-1:0] p0_ff, p1_ff;
   logic signed [vrpr_pkg::BLEND_P_W-1:0] blend_sum;
   logic signed [SB-1:0]               x2_ff, x3_ff;
   logic signed [CB-1:0]               cb_ff;
   logic signed [vrpr_pkg::MUL_W-1:0]  m_ff;
   logic signed [vrpr_pkg::ACC_W-1:0]  acc_ff;
   logic signed [vrpr_pkg::WB_W+1:0]   wb, wa;
   logic [SB-1:0]                      xa, xb;

   assign wb = $signed({2'b00, phase_ff[vrpr_pkg::PHASE_FRAC_BITS-1 -: vrpr_pkg::WB_W]});
   assign wa = $signed((vrpr_pkg::WB_W+2)'(1 << vrpr_pkg::WB_W)) - wb;
   assign xa = hva_ff ? hist_da : '0;
   assign xb = hvb_ff ? hist_db : '0;
   assign blend_sum = p0_ff + p1_ff +
                      vrpr_pkg::BLEND_P_W'(1 << (vrpr_pkg::WB_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.mac_issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      h1_ff <= tap_h;
      p0_ff <= wa * $signed(coef_da);
      p1_ff <= wb * $signed(coef_db);
      x2_ff <= $signed(h1_ff ? xb : xa);
      cb_ff <= blend_sum[vrpr_pkg::WB_W +: CB];
      x3_ff <= x2_ff;
      m_ff  <= x3_ff * cb_ff;
      if (cmd.mac_clear) begin
         acc_ff <= '0;
      end else if (v4_ff) begin
         acc_ff <= acc_ff + vrpr_pkg::ACC_W'(m_ff);
      end
   end

   // Round and saturate the result, give zero once zero samples fill the window, and hold it
   logic signed [vrpr_pkg::ACC_W-1:0] acc_rnd;
   logic signed [YW-1:0]              y_full;
   logic [SB-1:0]                     y_sat;
   logic signed [YW-1:0]              y_top, y_bot;

   assign acc_rnd = acc_ff + vrpr_pkg::ACC_W'(1 << (vrpr_pkg::OUT_SHIFT - 1));
   assign y_full  = YW'(acc_rnd >>> vrpr_pkg::OUT_SHIFT);
   assign y_top   = YW'((1 << (SB - 1)) - 1);
   assign y_bot   = -y_top - YW'(1);

   always_comb begin
      if (zr_ff >= two_hl) begin
         y_sat = '0;
      end else if (y_full > y_top) begin
         y_sat = y_top[SB-1:0];
      end else if (y_full < y_bot) begin
         y_sat = y_bot[SB-1:0];
      end else begin
         y_sat = y_full[SB-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_tdata <= y_sat;
         rsp_tlast <= cmd.out_last;
      end
   end

   assign status.sn_zero  = (sn_ff == '0);
   assign status.sn_one   = (sn_ff == SNW'(1));
   assign status.div_busy = div_busy_ff;
   assign status.mac_busy = v1_ff | v2_ff | v3_ff | v4_ff;
   assign status.two_hl   = two_hl;

   `VRPR_ASSERT_SAME(a_div_count, div_busy_ff,
      div_cnt_ff < vrpr_pkg::DIV_CNT_W'(vrpr_pkg::SUM_INT_W), "divider ran past last bit")
   `VRPR_ASSERT_NEXT(a_acc_hold, !v4_ff && !cmd.mac_clear, $stable(acc_ff),
      "accumulator moved without a tap product")
   `VRPR_ASSERT_SAME(a_no_sample_in_mac, cmd.sample_wr, !status.mac_busy,
      "history written while taps in flight")

endmodule

// ===== src/variable_ratio_polyphase_resampler_core.sv =====
// Variable-ratio polyphase FIR resampler: top level joining controller and datapath.
//
// Usage:
//   req channel: one item per transfer; req_tuser gives the kind (real sample, zero
//   sample, coefficient word), req_tdata carries sample and coefficient fields.
//   rsp channel: resampled outputs; rsp_tlast marks the final output of an input item.
//   csr channel: register writes (index, data), taken while reset is low; write only when idle.
// Sequencing:
//   Coefficient and ignored items are taken in the idle state. Each output runs a phase
//   division for the coefficient row, a tap walk over 2*half_length taps (two coefficient
//   reads per cycle from the dual-read coefficient memory), pipe drain, the step multiply
//   and update, and a second phase division that advances phase and window. The next
//   item is taken once all outputs of the current one are formed.
// Reset:
//   Synchronous, active high. History reads as zero, phase and window start at zero,
//   registers take their default values; the coefficient memory is not cleared.
// Stalls:
//   One output register parts the result side; a stalled receiver holds the datapath
//   before it loads the next output.
`timescale 1ns / 1ps
module variable_ratio_polyphase_resampler_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [23:0] sample_in, [36:24] coef_addr, [60:37] coef_value, [63:61] zero
   input  logic [vrpr_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [1:0] op
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [23:0] out_sample
   output logic [vrpr_pkg::SAMPLE_BITS-1:0]    rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [vrpr_pkg::STEP_W-1:0]         csr_data
);

   vrpr_pkg::ctl_cmd_type   cmd;
   vrpr_pkg::dp_status_type status;
   logic                    csr_wr;

   assign csr_ready = ~reset;
   assign csr_wr    = csr_valid & csr_ready;

   vrpr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   vrpr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_wr),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

endmodule

// ===== tb/sv/variable_ratio_polyphase_resampler_core_tb.sv =====
// Self-checking testbench for the variable-ratio polyphase resampler core.
`timescale 1ns / 1ps
module variable_ratio_polyphase_resampler_core_tb;
   import vrpr_pkg::*;

   localparam longint ONE_ROW   = 64'd1 << PHASE_FRAC_BITS;
   localparam int     RUN_LIMIT = 25000000;

   typedef struct {
      logic [1:0]  op;
      logic [23:0] smp;
      logic [12:0] addr;
      logic [23:0] cval;
   } item_t;

   typedef struct {
      logic [SAMPLE_BITS-1:0] smp;
      logic                   last;
   } out_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [1:0] req_tuser = OP_REAL;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [SAMPLE_BITS-1:0] rsp_tdata;
   logic rsp_tlast;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = REG_HALF_LENGTH;
   logic [STEP_W-1:0] csr_data = '0;

   variable_ratio_polyphase_resampler_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   // Shadow copy of the resampler state
   longint coef_mem [COEF_DEPTH];
   longint ring [RING_LEN];
   int     win_start, need_cnt, zrun;
   longint ph, ph_step;
   bit     started;
   int     reg_hl, reg_np;
   longint reg_step, reg_weight;

   item_t  pending_items [$];
   out_t   expected_outs [$];
   item_t  cur_item;
   int     errors = 0;
   int     outs_seen = 0;
   int     gap_left = 0;
   int     stall_left = 0;
   int     hold_left = 0;
   bit     quiet = 1'b0;
   bit     pressure_done = 1'b0;
   int     cycles = 0;

   function automatic int clamp_hl();
      return reg_hl < HL_MIN ? HL_MIN : (reg_hl > MAX_HALF_LENGTH ? MAX_HALF_LENGTH : reg_hl);
   endfunction

   function automatic int clamp_np();
      return reg_np < NP_MIN ? NP_MIN : (reg_np > MAX_PHASES ? MAX_PHASES : reg_np);
   endfunction

   function automatic longint mix_coef(int i0, int i1, longint wa, longint wb);
      return (wa * coef_mem[i0 % COEF_DEPTH] + wb * coef_mem[i1 % COEF_DEPTH] + 32768) >>> 16;
   endfunction

   function automatic longint filter_out(int hl, int np);
      longint wa, wb, acc, y;
      int k, r1, r2;
      acc = 0;
      if (zrun >= 2 * hl) return 0;
      k  = int'((ph >> PHASE_FRAC_BITS) % np);
      wb = (ph & (ONE_ROW - 1)) >> (PHASE_FRAC_BITS - 16);
      wa = 65536 - wb;
      r1 = k * hl;
      r2 = (np - k) * hl;
      for (int i = 0; i < hl; i++)
         acc += ring[(win_start + i) % RING_LEN] * mix_coef(r1 + i, r1 + hl + i, wa, wb)
              + ring[(win_start + 2 * hl - 1 - i) % RING_LEN]
                * mix_coef(r2 + i, r2 - hl + i, wa, wb);
      y = (acc + (64'sd1 <<< 22)) >>> 23;
      if (y > 8388607) y = 8388607;
      if (y < -8388608) y = -8388608;
      return y;
   endfunction

   // Smooth the step toward its target, then move the phase
   function automatic void step_phase(int hl, int np);
      longint d, prod, inc, lim, n;
      d    = reg_step - ph_step;
      prod = reg_weight * d;
      inc  = prod >= 0 ? (prod >>> 16) : -((-prod) >>> 16);
      lim  = longint'(np) << PHASE_FRAC_BITS;
      if (inc == 0 && d != 0 && reg_weight != 0) ph_step = reg_step;
      else ph_step = ph_step + inc;
      ph += ph_step;
      if (ph >= lim) begin
         n = ph / lim;
         ph -= n * lim;
         win_start = int'((win_start + n) % RING_LEN);
         need_cnt = n > 2 * hl ? 2 * hl : int'(n);
      end
   endfunction

   function automatic void emit_ready(int hl, int np, ref int cnt);
      out_t o;
      while (need_cnt == 0 && cnt < RESULT_CAP) begin
         o.smp  = SAMPLE_BITS'(filter_out(hl, np));
         o.last = 1'b0;
         expected_outs.push_back(o);
         cnt++;
         step_phase(hl, np);
      end
   endfunction

   // Work out the outputs one accepted item causes
   function automatic void predict_outputs(item_t it);
      int hl, np, cnt, pos;
      hl  = clamp_hl();
      np  = clamp_np();
      cnt = 0;
      if (it.op == OP_COEF) begin
         if (it.addr < COEF_DEPTH) coef_mem[it.addr] = longint'($signed(it.cval));
         return;
      end
      if (it.op == OP_NONE) return;
      if (!started) begin
         ph_step = reg_step;
         started = 1'b1;
      end
      emit_ready(hl, np, cnt);
      if (need_cnt > 0) begin
         pos = (win_start + 2 * hl + RING_LEN - need_cnt % RING_LEN) % RING_LEN;
         if (it.op == OP_REAL) begin
            ring[pos] = longint'($signed(it.smp));
            zrun = 0;
         end else begin
            ring[pos] = 0;
            if (zrun < 2 * hl) zrun++;
         end
         need_cnt--;
         emit_ready(hl, np, cnt);
      end
      if (cnt > 0) expected_outs[expected_outs.size() - 1].last = 1'b1;
   endfunction

   function automatic void add_item(logic [1:0] op, logic [23:0] smp, logic [12:0] addr,
                                    logic [23:0] cval);
      item_t it;
      it.op = op; it.smp = smp; it.addr = addr; it.cval = cval;
      pending_items.push_back(it);
   endfunction

   // Fill the table entries from lo up to hi, exclusive
   function automatic void add_table(int lo, int hi);
      for (int a = lo; a < hi; a++)
         add_item(OP_COEF, 24'($urandom), 13'(a),
                  24'(int'($urandom_range(0, 1048575)) - 524288));
   endfunction

   function automatic void add_random(int n, int hl);
      int r, run;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 3) add_item(OP_NONE, 24'($urandom), 13'($urandom), 24'($urandom));
         else if (r < 9) add_item(OP_COEF, 24'($urandom), 13'($urandom), 24'($urandom));
         else if (r < 11) begin
            run = 2 * hl + $urandom_range(1, 4);
            for (int j = 0; j < run; j++)
               add_item(OP_ZERO, 24'($urandom), 13'($urandom), 24'($urandom));
         end else if (r < 20) add_item(OP_ZERO, 24'($urandom), 13'($urandom), 24'($urandom));
         else add_item(OP_REAL, 24'($urandom), 13'($urandom), 24'($urandom));
      end
   endfunction

   task automatic write_reg(logic [1:0] idx, longint val);
      csr_index <= idx;
      csr_data  <= STEP_W'(val);
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_HALF_LENGTH: reg_hl = int'(val & 'h7F);
         REG_NUM_PHASES:  reg_np = int'(val & 'h7F);
         REG_TARGET_STEP: reg_step = val & ((64'd1 << STEP_W) - 1);
         default:         reg_weight = val & 'hFFFF;
      endcase
   endtask

   // Wait for the block to drain, set all registers and load new table entries
   task automatic start_phase(int hl, int np, longint stp, longint wt, int tbl_lo,
                              int tbl_hi);
      while (pending_items.size() != 0 || req_tvalid || expected_outs.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      write_reg(REG_HALF_LENGTH, hl);
      write_reg(REG_NUM_PHASES, np);
      write_reg(REG_TARGET_STEP, stp);
      write_reg(REG_STEP_WEIGHT, wt);
      add_table(tbl_lo, tbl_hi);
   endtask

   // Stimulus
   initial begin
      for (int i = 0; i < COEF_DEPTH; i++) coef_mem[i] = 0;
      for (int i = 0; i < RING_LEN; i++) ring[i] = 0;
      reg_hl = 32; reg_np = 32;
      reg_step = longint'(STEP_RESET); reg_weight = longint'(WEIGHT_RESET);
      win_start = 0; need_cnt = 64; zrun = 0; ph = 0; ph_step = reg_step; started = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      start_phase(16, 2, 3 * ONE_ROW / 2, 655, 0, 48);
      add_item(OP_COEF, 24'd0, 13'd4159, 24'h7FFFFF);
      add_item(OP_COEF, 24'd0, 13'd8191, 24'h800000);
      add_item(OP_COEF, 24'd0, 13'd4160, 24'h123456);
      add_item(OP_COEF, 24'd0, 13'd5, 24'h7FFFFF);
      add_item(OP_COEF, 24'd0, 13'd40, 24'h800000);
      add_item(OP_REAL, 24'h7FFFFF, 13'd0, 24'd0);
      add_item(OP_REAL, 24'h800000, 13'd0, 24'd0);
      add_item(OP_REAL, 24'h000000, 13'h1FFF, 24'hFFFFFF);
      add_item(OP_REAL, 24'hFFFFFF, 13'd0, 24'd0);
      add_item(OP_ZERO, 24'h7FFFFF, 13'd0, 24'd0);
      add_item(OP_NONE, 24'hFFFFFF, 13'h1FFF, 24'hFFFFFF);
      add_item(OP_ZERO, 24'd0, 13'd0, 24'd0);
      for (int i = 0; i < 8; i++) add_item(OP_REAL, 24'h7FFFFF, 13'd0, 24'd0);
      for (int i = 0; i < 4; i++) add_item(OP_REAL, 24'h800000, 13'd0, 24'd0);
      add_random(35, 16);

      // More rows and a fast-settling step
      start_phase(16, 6, 5 * ONE_ROW + longint'($urandom), 65535, 48, 112);
      add_random(30, 16);
      // Smallest step: the result cap carries outputs over
      start_phase(16, 6, 1, 65535, 0, 0);
      for (int i = 0; i < 5; i++) add_item(OP_REAL, 24'($urandom), 13'd0, 24'd0);
      // Oversized step, with fewer rows than the phase may already hold
      start_phase(16, 2, (64'd1 << STEP_W) - 1, 65535, 0, 0);
      add_random(30, 16);
      // Longest filter
      start_phase(64, 2, 17 * ONE_ROW / 10 + longint'($urandom), 40000, 112, 192);
      add_random(20, 64);
      // Settings below the working range clamp to it
      start_phase(3, 1, 13 * ONE_ROW / 10 + longint'($urandom), 655, 0, 0);
      quiet = 1'b1;
      add_random(30, 16);

      while (pending_items.size() != 0 || req_tvalid || expected_outs.size() != 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
      if (errors == 0 && expected_outs.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Input driver: predict on each transfer, then offer the next item
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) predict_outputs(cur_item);
         if (req_tvalid && !req_tready) begin
            // hold the offered item
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            if (!quiet && $urandom_range(0, 9) == 0) begin
               gap_left = $urandom_range(0, 3);
               req_tvalid <= 1'b0;
            end else begin
               cur_item = pending_items.pop_front();
               req_tuser <= cur_item.op;
               req_tdata <= {3'b000, cur_item.cval, cur_item.addr, cur_item.smp};
               req_tvalid <= 1'b1;
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Long receiver hold-off, counted on its own
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
      else if (!pressure_done && outs_seen >= 40) begin
         hold_left <= 600;
         pressure_done <= 1'b1;
      end
   end

   // Output monitor: check each transfer against the oldest expectation
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            outs_seen++;
            if (expected_outs.size() == 0) begin
               errors++;
               $display("%0t: unexpected output: expected none, actual %h last %b",
                        $realtime, rsp_tdata, rsp_tlast);
            end else begin
               out_t e;
               e = expected_outs.pop_front();
               if (e.smp !== rsp_tdata) begin
                  errors++;
                  $display("%0t: out_sample mismatch: expected %h, actual %h",
                           $realtime, e.smp, rsp_tdata);
               end
               if (e.last !== rsp_tlast) begin
                  errors++;
                  $display("%0t: last mismatch: expected %b, actual %b",
                           $realtime, e.last, rsp_tlast);
               end
            end
         end
         if (hold_left > 0) rsp_tready <= 1'b0;
         else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            rsp_tready <= 1'b0;
         end else rsp_tready <= 1'b1;
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > RUN_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

endmodule

// ===== variable_ratio_polyphase_resampler_core.f =====
+incdir+src
src/vrpr_pkg.sv
src/vrpr_ram.sv
src/vrpr_ctrl.sv
src/vrpr_datapath.sv
src/variable_ratio_polyphase_resampler_core.sv
tb/sv/variable_ratio_polyphase_resampler_core_tb.sv
